/* src/prsh_pkg.sv */
// Shared types and constants for the pointer-reversal mark/sweep cell heap.
// No dependencies; used by every module of the block.
package prsh_pkg;

   localparam logic [2:0] CMD_WRITE = 3'd0;
   localparam logic [2:0] CMD_READ  = 3'd1;
   localparam logic [2:0] CMD_MARK  = 3'd2;
   localparam logic [2:0] CMD_SWEEP = 3'd3;
   localparam logic [2:0] CMD_ALLOC = 3'd4;
   localparam logic [2:0] CMD_FREE  = 3'd5;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_BAD   = 2'd2;

   localparam logic REG_HEAP_END = 1'b0;
   localparam logic REG_RESERVED = 1'b1;

   // kind tested in bits 5:4 of a type byte
   localparam logic [5:0] KIND_NO_RIGHT = 6'h30;
   localparam logic [5:0] KIND_NO_LEFT  = 6'h20;

   localparam logic [12:0] HEAP_END_RESET = 13'd4096;
   localparam logic [15:0] ALLOC_NONE     = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] cell_address;
      logic [15:0] left_link;
      logic [15:0] right_link;
      logic [1:0]  link_kind;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] read_left;
      logic [15:0] read_right;
      logic [1:0]  read_kind;
      logic        read_marked;
      logic [15:0] allocated_cell;
      logic [12:0] free_total;
   } rsp_type;

   typedef struct packed {
      logic left;
      logic right;
      logic kind;
      logic mark;
      logic flip;
   } wr_en_type;

endpackage

/* src/pointer_reversal_mark_sweep_heap.sv */
// Garbage-collected cell heap: write, read, mark, sweep, allocate, free.
// Write, free and bad-address requests answer without a memory read; read and
// allocate read one cell first. Mark walks and sweep scans one cell per read-evaluate step.
// One request at a time; the cell memory read-evaluate-write loop sets the rate.
// Reset runs a mark/flip clearing pass over all HEAP_CELLS cells, requests stalled.
// Depends on prsh_pkg and prsh_cell_mem.
module pointer_reversal_mark_sweep_heap #(
   parameter int HEAP_CELLS   = 4096,
   parameter int POINTER_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  prsh_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output prsh_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [12:0]       csr_write_data
);
   import prsh_pkg::*;

   localparam int AW = $clog2(HEAP_CELLS);
   localparam int PW = POINTER_BITS;
   localparam int XW = (AW + 1 > 16) ? AW + 1 : 16;
   localparam logic [PW-1:0] NIL = {PW{1'b1}};

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RESP, S_READ_EV, S_ALLOC_EV, S_SWP_CHK, S_SWP_EV,
      S_FWD_RD, S_FWD_EV, S_BACK_CHK, S_BACK_EV, S_CLIMB_CHK, S_CLIMB_EV
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [PW-1:0] cur_ff, cur_in, back_ff, back_in, head_ff, head_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [12:0]   count_ff, count_in, total_ff, total_in;
   logic [12:0]   heap_end_ff, reserved_ff;
   rsp_type       res_ff, res_in, rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [AW-1:0] rd_addr, wr_addr;
   wr_en_type     wr_en;
   logic [PW-1:0] rd_left, rd_right, wr_left, wr_right;
   logic [1:0]    rd_kind, wr_kind;
   logic          rd_mark, rd_flip, wr_mark, wr_flip;

   logic [XW-1:0] end_x, addr_x;
   logic          addr_bad;

   assign end_x = (XW'(heap_end_ff) < XW'(HEAP_CELLS)) ? XW'(heap_end_ff)
                                                       : XW'(HEAP_CELLS);
   assign addr_x   = XW'(req_data.cell_address);
   assign addr_bad = addr_x >= end_x;

   function automatic logic ptr_ok(input logic [PW-1:0] p, input logic [XW-1:0] e);
      return XW'(p) < e;
   endfunction

   function automatic logic [AW-1:0] ptr_idx(input logic [PW-1:0] p);
      logic [XW-1:0] w;
      w = XW'(p);
      return w[AW-1:0];
   endfunction

   prsh_cell_mem #(.DEPTH(HEAP_CELLS), .AW(AW), .PW(PW)) u_mem (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .rd_left  (rd_left),
      .rd_right (rd_right),
      .rd_kind  (rd_kind),
      .rd_mark  (rd_mark),
      .rd_flip  (rd_flip),
      .wr_addr  (wr_addr),
      .wr_en    (wr_en),
      .wr_left  (wr_left),
      .wr_right (wr_right),
      .wr_kind  (wr_kind),
      .wr_mark  (wr_mark),
      .wr_flip  (wr_flip)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      back_in      = back_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr      = '0;
      wr_addr      = '0;
      wr_en        = '0;
      wr_left      = '0;
      wr_right     = '0;
      wr_kind      = '0;
      wr_mark      = 1'b0;
      wr_flip      = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_addr    = clr_ff;
            wr_en.mark = 1'b1;
            wr_en.flip = 1'b1;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == AW'(HEAP_CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               state_in = S_RESP;
               unique case (req_data.command)
                  CMD_WRITE: begin
                     if (addr_bad) begin
                        res_in.status = STATUS_BAD;
                     end else begin
                        wr_addr     = addr_x[AW-1:0];
                        wr_en.left  = 1'b1;
                        wr_en.right = 1'b1;
                        wr_en.kind  = 1'b1;
                        wr_left     = req_data.left_link[PW-1:0];
                        wr_right    = req_data.right_link[PW-1:0];
                        wr_kind     = req_data.link_kind;
                     end
                  end
                  CMD_READ: begin
                     if (addr_bad) begin
                        res_in.status = STATUS_BAD;
                     end else begin
                        rd_addr  = addr_x[AW-1:0];
                        state_in = S_READ_EV;
                     end
                  end
                  CMD_MARK: begin
                     cur_in   = req_data.cell_address[PW-1:0];
                     back_in  = NIL;
                     state_in = S_FWD_RD;
                  end
                  CMD_SWEEP: begin
                     head_in  = NIL;
                     count_in = '0;
                     cnt_in   = end_x[AW:0];
                     state_in = S_SWP_CHK;
                  end
                  CMD_ALLOC: begin
                     if (!ptr_ok(head_ff, end_x)) begin
                        res_in.status         = STATUS_EMPTY;
                        res_in.allocated_cell = ALLOC_NONE;
                     end else begin
                        rd_addr  = ptr_idx(head_ff);
                        state_in = S_ALLOC_EV;
                     end
                  end
                  CMD_FREE: begin
                     if (addr_bad) begin
                        res_in.status = STATUS_BAD;
                     end else begin
                        wr_addr     = addr_x[AW-1:0];
                        wr_en.kind  = 1'b1;
                        wr_en.right = 1'b1;
                        wr_right    = head_ff;
                        head_in     = req_data.cell_address[PW-1:0];
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ_EV: begin
            res_in.read_left   = 16'(rd_left);
            res_in.read_right  = 16'(rd_right);
            res_in.read_kind   = rd_kind;
            res_in.read_marked = rd_mark;
            state_in           = S_RESP;
         end
         S_ALLOC_EV: begin
            res_in.allocated_cell = 16'(head_ff);
            head_in               = rd_right;
            state_in              = S_RESP;
         end
         S_SWP_CHK: begin
            if (cnt_ff == '0) begin
               total_in = count_ff;
               state_in = S_RESP;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               rd_addr  = AW'(cnt_ff - 1'b1);
               state_in = S_SWP_EV;
            end
         end
         S_SWP_EV: begin
            wr_addr = cnt_ff[AW-1:0];
            if (rd_mark || XW'(cnt_ff) < XW'(reserved_ff)) begin
               wr_en.mark = 1'b1;
            end else begin
               wr_en.kind  = 1'b1;
               wr_en.right = 1'b1;
               wr_right    = head_ff;
               head_in     = PW'(cnt_ff);
               count_in    = count_ff + 1'b1;
            end
            state_in = S_SWP_CHK;
         end
         S_FWD_RD: begin
            if (ptr_ok(cur_ff, end_x)) begin
               rd_addr  = ptr_idx(cur_ff);
               state_in = S_FWD_EV;
            end else begin
               state_in = S_BACK_CHK;
            end
         end
         S_FWD_EV: begin
            state_in = S_BACK_CHK;
            if (!rd_mark) begin
               wr_addr    = ptr_idx(cur_ff);
               wr_en.mark = 1'b1;
               wr_mark    = 1'b1;
               if (({rd_kind, 4'b0} & KIND_NO_LEFT) == '0) begin
                  wr_en.left = 1'b1;
                  wr_left    = back_ff;
                  back_in    = cur_ff;
                  cur_in     = rd_left;
                  state_in   = S_FWD_RD;
               end
            end
         end
         S_BACK_CHK: begin
            if (ptr_ok(back_ff, end_x)) begin
               rd_addr  = ptr_idx(back_ff);
               state_in = S_BACK_EV;
            end else begin
               state_in = S_RESP;
            end
         end
         S_BACK_EV: begin
            wr_addr = ptr_idx(back_ff);
            if (rd_flip) begin
               wr_en.flip  = 1'b1;
               wr_en.right = 1'b1;
               wr_right    = cur_ff;
               cur_in      = back_ff;
               back_in     = rd_right;
               state_in    = S_BACK_CHK;
            end else if (({rd_kind, 4'b0} & KIND_NO_RIGHT) == '0) begin
               wr_en.left  = 1'b1;
               wr_en.flip  = 1'b1;
               wr_en.right = 1'b1;
               wr_left     = cur_ff;
               wr_flip     = 1'b1;
               wr_right    = rd_left;
               cur_in      = rd_right;
               state_in    = S_FWD_RD;
            end else begin
               wr_en.left = 1'b1;
               wr_left    = cur_ff;
               cur_in     = back_ff;
               back_in    = rd_left;
               state_in   = S_CLIMB_CHK;
            end
         end
         S_CLIMB_CHK: begin
            if (ptr_ok(back_ff, end_x)) begin
               rd_addr  = ptr_idx(back_ff);
               state_in = S_CLIMB_EV;
            end else begin
               state_in = S_FWD_RD;
            end
         end
         S_CLIMB_EV: begin
            if (({rd_kind, 4'b0} & KIND_NO_RIGHT) != '0) begin
               wr_addr    = ptr_idx(back_ff);
               wr_en.left = 1'b1;
               wr_left    = cur_ff;
               cur_in     = back_ff;
               back_in    = rd_left;
               state_in   = S_CLIMB_CHK;
            end else begin
               state_in = S_FWD_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in            = res_ff;
               rsp_in.free_total = total_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         head_ff      <= NIL;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         heap_end_ff  <= HEAP_END_RESET;
         reserved_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_HEAP_END: heap_end_ff <= csr_write_data;
               REG_RESERVED: reserved_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
      cur_ff   <= cur_in;
      back_ff  <= back_in;
      cnt_ff   <= cnt_in;
      count_ff <= count_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/prsh_cell_mem.sv */
// Cell storage: link, kind, mark and flip arrays, one registered read port
// and one write port with per-field enables. Depends on prsh_pkg.
module prsh_cell_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int PW    = 16
) (
   input  logic                clock,
   input  logic [AW-1:0]       rd_addr,
   output logic [PW-1:0]       rd_left,
   output logic [PW-1:0]       rd_right,
   output logic [1:0]          rd_kind,
   output logic                rd_mark,
   output logic                rd_flip,
   input  logic [AW-1:0]       wr_addr,
   input  prsh_pkg::wr_en_type wr_en,
   input  logic [PW-1:0]       wr_left,
   input  logic [PW-1:0]       wr_right,
   input  logic [1:0]          wr_kind,
   input  logic                wr_mark,
   input  logic                wr_flip
);
   import prsh_pkg::*;

   logic [PW-1:0] left_mem  [DEPTH];
   logic [PW-1:0] right_mem [DEPTH];
   logic [1:0]    kind_mem  [DEPTH];
   logic          mark_mem  [DEPTH];
   logic          flip_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en.left)  left_mem[wr_addr]  <= wr_left;
      if (wr_en.right) right_mem[wr_addr] <= wr_right;
      if (wr_en.kind)  kind_mem[wr_addr]  <= wr_kind;
      if (wr_en.mark)  mark_mem[wr_addr]  <= wr_mark;
      if (wr_en.flip)  flip_mem[wr_addr]  <= wr_flip;
   end

   always_ff @(posedge clock) begin
      rd_left  <= left_mem[rd_addr];
      rd_right <= right_mem[rd_addr];
      rd_kind  <= kind_mem[rd_addr];
      rd_mark  <= mark_mem[rd_addr];
      rd_flip  <= flip_mem[rd_addr];
   end

endmodule

/* src/prsh_checker.sv */
// Port-level checks for the cell heap and the bind that attaches them.
// Depends on prsh_pkg and pointer_reversal_mark_sweep_heap.
module prsh_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input prsh_pkg::rsp_type rsp_data
);
   import prsh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_empty_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY |-> rsp_data.allocated_cell == ALLOC_NONE)
      else $error("empty allocate without nil cell");

   a_bad_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_BAD |->
         rsp_data.read_left == '0 && rsp_data.read_right == '0 &&
         rsp_data.allocated_cell == '0)
      else $error("bad address response carries data");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind pointer_reversal_mark_sweep_heap prsh_checker u_prsh_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* sim/prsh_heap_checker.sv */
// Checker for the pointer-reversal mark/sweep cell heap: watches the request,
// response and register ports, predicts every response and compares it.
// Depends on prsh_pkg.
module prsh_heap_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  prsh_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  prsh_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [12:0]       csr_write_data,
   output int                fail_count,
   output int                outstanding
);
   import prsh_pkg::*;

   localparam int CELLS = 4096;
   localparam int NIL = 16'hFFFF;

   logic [15:0] cell_left [CELLS];
   logic [15:0] cell_right [CELLS];
   logic [1:0]  cell_kind [CELLS];
   logic        cell_mark [CELLS];
   logic        cell_flip [CELLS];
   logic [15:0] list_head;
   logic [12:0] swept_total;
   logic [12:0] heap_end;
   logic [12:0] reserved_count;
   rsp_type     expected_rsp_q[$];

   function automatic int heap_limit();
      return (heap_end < CELLS) ? int'(heap_end) : CELLS;
   endfunction

   function automatic logic follows_left(int c);
      return ({cell_kind[c], 4'b0} & KIND_NO_LEFT) == 6'h0;
   endfunction

   function automatic logic follows_right(int c);
      return ({cell_kind[c], 4'b0} & KIND_NO_RIGHT) == 6'h0;
   endfunction

   task automatic mark_walk(input int root);
      int lim, cur, back, nx;
      lim = heap_limit();
      cur = root;
      back = NIL;
      forever begin
         while (cur < lim && !cell_mark[cur]) begin
            cell_mark[cur] = 1'b1;
            if (follows_left(cur)) begin
               nx = int'(cell_left[cur]);
               cell_left[cur] = back[15:0];
               back = cur;
               cur = nx;
            end
         end
         while (back < lim && cell_flip[back]) begin
            cell_flip[back] = 1'b0;
            nx = int'(cell_right[back]);
            cell_right[back] = cur[15:0];
            cur = back;
            back = nx;
         end
         if (back >= lim) break;
         if (follows_right(back)) begin
            nx = int'(cell_left[back]);
            cell_left[back] = cur[15:0];
            cell_flip[back] = 1'b1;
            cur = int'(cell_right[back]);
            cell_right[back] = nx[15:0];
         end else begin
            while (back < lim && !follows_right(back)) begin
               nx = int'(cell_left[back]);
               cell_left[back] = cur[15:0];
               cur = back;
               back = nx;
            end
         end
      end
   endtask

   task automatic sweep_cells();
      int c, count;
      count = 0;
      list_head = 16'(NIL);
      for (c = heap_limit() - 1; c >= 0; c--) begin
         if (cell_mark[c] || c < int'(reserved_count)) begin
            cell_mark[c] = 1'b0;
         end else begin
            cell_kind[c] = 2'd0;
            cell_right[c] = list_head;
            list_head = c[15:0];
            count++;
         end
      end
      swept_total = count[12:0];
   endtask

   task automatic heap_response(input req_type r, output rsp_type o);
      int lim, a;
      lim = heap_limit();
      a = int'(r.cell_address);
      o = '0;
      case (r.command)
         CMD_WRITE, CMD_READ, CMD_FREE: begin
            if (a >= lim) begin
               o.status = STATUS_BAD;
            end else if (r.command == CMD_WRITE) begin
               cell_left[a] = r.left_link;
               cell_right[a] = r.right_link;
               cell_kind[a] = r.link_kind;
            end else if (r.command == CMD_READ) begin
               o.read_left = cell_left[a];
               o.read_right = cell_right[a];
               o.read_kind = cell_kind[a];
               o.read_marked = cell_mark[a];
            end else begin
               cell_kind[a] = 2'd0;
               cell_right[a] = list_head;
               list_head = a[15:0];
            end
         end
         CMD_MARK: mark_walk(a);
         CMD_SWEEP: sweep_cells();
         CMD_ALLOC: begin
            if (int'(list_head) >= lim) begin
               o.status = STATUS_EMPTY;
               o.allocated_cell = ALLOC_NONE;
            end else begin
               o.allocated_cell = list_head;
               list_head = cell_right[list_head];
            end
         end
         default: ;
      endcase
      o.free_total = swept_total;
   endtask

   task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e, o;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            cell_left[i] = '0;
            cell_right[i] = '0;
            cell_kind[i] = '0;
            cell_mark[i] = 1'b0;
            cell_flip[i] = 1'b0;
         end
         list_head = 16'(NIL);
         swept_total = '0;
         heap_end = HEAP_END_RESET;
         reserved_count = '0;
         expected_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == REG_HEAP_END) heap_end = csr_write_data;
            else reserved_count = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count++;
            end else begin
               e = expected_rsp_q.pop_front();
               check_field("status", 16'(e.status), 16'(rsp_data.status));
               check_field("read_left", e.read_left, rsp_data.read_left);
               check_field("read_right", e.read_right, rsp_data.read_right);
               check_field("read_kind", 16'(e.read_kind), 16'(rsp_data.read_kind));
               check_field("read_marked", 16'(e.read_marked), 16'(rsp_data.read_marked));
               check_field("allocated_cell", e.allocated_cell, rsp_data.allocated_cell);
               check_field("free_total", 16'(e.free_total), 16'(rsp_data.free_total));
            end
         end
         if (req_valid && !req_stall) begin
            heap_response(req_data, o);
            expected_rsp_q.push_back(o);
         end
      end
      outstanding = expected_rsp_q.size();
   end

endmodule

/* sim/pointer_reversal_mark_sweep_heap_tb.sv */
// Testbench top for the pointer-reversal mark/sweep cell heap: clock, reset,
// request and register stimulus, receiver stalls and the verdict.
// Depends on prsh_pkg, pointer_reversal_mark_sweep_heap and prsh_heap_checker.
module pointer_reversal_mark_sweep_heap_tb;
   import prsh_pkg::*;

   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;
   localparam int CYCLE_LIMIT = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = REG_HEAP_END;
   logic [12:0] csr_write_data = '0;
   int          fail_count, outstanding;
   int          cycles = 0;
   int          sent = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        want_hold = 1'b0;
   int          hold_left = 0;
   int          cur_limit = 4096;
   logic        written [4096];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pointer_reversal_mark_sweep_heap DUT (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_write_enable, .csr_index, .csr_write_data
   );

   prsh_heap_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_write_enable, .csr_index, .csr_write_data, .fail_count,
      .outstanding
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver stalls; long hold-off when requested
   always @(negedge clock) begin
      if (want_hold) begin
         want_hold = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   function automatic logic [1:0] rand2();
      return 2'($urandom);
   endfunction

   function automatic req_type make_req(logic [2:0] c, logic [15:0] a, logic [15:0] l,
                                        logic [15:0] r, logic [1:0] k);
      req_type q;
      q.command = c;
      q.cell_address = a;
      q.left_link = l;
      q.right_link = r;
      q.link_kind = k;
      return q;
   endfunction

   task automatic send_req(input req_type r);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(5, 1)) @(negedge clock);
      end
      req_data = r;
      req_valid = 1'b1;
      if (r.command == CMD_WRITE && int'(r.cell_address) < cur_limit)
         written[r.cell_address] = 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [12:0] v);
      drain();
      csr_index = idx;
      csr_write_data = v;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == REG_HEAP_END) cur_limit = (v < 13'd4096) ? int'(v) : 4096;
   endtask

   function automatic logic [15:0] pick_link();
      int w;
      w = $urandom_range(9);
      if (w < 7 && cur_limit > 0) return 16'($urandom_range(cur_limit - 1));
      if (w == 7) return 16'hFFFF;
      return rand16();
   endfunction

   // every cell in use holds defined links before anything walks the heap
   task automatic fill_heap();
      for (int c = 0; c < cur_limit; c++)
         if (!written[c])
            send_req(make_req(CMD_WRITE, 16'(c), pick_link(), pick_link(), rand2()));
   endtask

   task automatic run_random(input int n, input logic wide);
      int w;
      logic [15:0] a;
      for (int i = 0; i < n; i++) begin
         w = $urandom_range(99);
         if (!wide && cur_limit > 0 && $urandom_range(9) < 8)
            a = 16'($urandom_range(cur_limit - 1));
         else a = rand16();
         if (w < 30) begin
            send_req(make_req(CMD_WRITE, a, pick_link(), pick_link(), rand2()));
         end else if (w < 50) begin
            if (wide) begin
               a = 16'($urandom_range(4095));
               if (!written[a]) a = 16'($urandom_range(63));
            end
            send_req(make_req(CMD_READ, a, rand16(), rand16(), rand2()));
         end else if (w < 62) begin
            if (wide) a = 16'(4096 + $urandom_range(61439));
            send_req(make_req(CMD_MARK, a, rand16(), rand16(), rand2()));
         end else if (w < 67 && !wide) begin
            send_req(make_req(CMD_SWEEP, rand16(), rand16(), rand16(), rand2()));
         end else if (w < 82 && !wide) begin
            send_req(make_req(CMD_ALLOC, rand16(), rand16(), rand16(), rand2()));
         end else if (w < 94) begin
            if (wide) a = 16'(4096 + $urandom_range(61439));
            send_req(make_req(CMD_FREE, a, rand16(), rand16(), rand2()));
         end else begin
            send_req(make_req($urandom_range(1) ? CMD_SPARE7 : CMD_SPARE6, rand16(),
                              rand16(), rand16(), rand2()));
         end
      end
   endtask

   // a heap above the cell count only reads written cells, so it needs no fill
   task automatic run_phase(input logic [12:0] hend, input logic [12:0] resv, input int n);
      write_reg(REG_HEAP_END, hend);
      write_reg(REG_RESERVED, resv);
      if (hend <= 13'd4096) fill_heap();
      run_random(n, hend > 13'd4096);
   endtask

   initial begin
      for (int i = 0; i < 4096; i++) written[i] = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 6;
      recv_idle_pct = 71;

      write_reg(REG_HEAP_END, 13'd16);
      write_reg(REG_RESERVED, 13'd0);
      fill_heap();
      // directed: link and kind extremes, every command, bad and nil addresses
      send_req(make_req(CMD_WRITE, 16'd0, 16'd1, 16'd2, 2'd0));
      send_req(make_req(CMD_WRITE, 16'd1, 16'hFFFF, 16'hFFFF, 2'd1));
      send_req(make_req(CMD_WRITE, 16'd2, 16'd0, 16'd0, 2'd2));
      send_req(make_req(CMD_WRITE, 16'd3, 16'd3, 16'd3, 2'd3));
      send_req(make_req(CMD_WRITE, 16'd15, 16'd0, 16'd15, 2'd0));
      send_req(make_req(CMD_WRITE, 16'hFFFF, 16'd1, 16'd1, 2'd0));
      send_req(make_req(CMD_READ, 16'd1, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_READ, 16'd16, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_MARK, 16'd0, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_MARK, 16'd15, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_MARK, 16'hFFFF, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_READ, 16'd0, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_ALLOC, 16'd0, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_SWEEP, 16'd0, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_READ, 16'd0, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_ALLOC, 16'd0, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_FREE, 16'd0, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_FREE, 16'd16, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_ALLOC, 16'd0, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_SPARE6, 16'd5, 16'd0, 16'd0, 2'd0));
      send_req(make_req(CMD_SPARE7, 16'd5, 16'd0, 16'd0, 2'd0));
      run_random(150, 1'b0);

      run_phase(13'd40, 13'd5, 60);
      want_hold = 1'b1;
      run_random(120, 1'b0);
      run_phase(13'd1, 13'd0, 40);

      send_idle_pct = 71;
      recv_idle_pct = 6;
      run_phase(13'd0, 13'd0, 30);
      run_phase(13'd24, 13'd8191, 60);
      run_phase(13'd64, 13'd64, 60);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(13'd8191, 13'd3, 120);
      run_phase(13'd32, 13'd2, 220);
      run_phase(13'd48, 13'd4096, 20);

      drain();
      repeat (20) @(negedge clock);
      $display("Sent %0d requests over heap sizes 0 to 8191 and reserved counts 0 to 8191,",
               sent);
      $display("with sender and receiver idling in turn and one long receiver hold-off.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
